// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the slot directory design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ===== design/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot directory package
// Page geometry, field widths, request and status codes, and shared types.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int unsigned PAGE_BYTES      = 4096;
	localparam int unsigned HEADER_BYTES    = 16;
	localparam int unsigned ENTRY_BYTES     = 8;
	localparam int unsigned MAX_ENTRIES_DEF = 512;

	localparam int unsigned OP_W   = 2;
	localparam int unsigned SLOT_W = 10;
	localparam int unsigned RLEN_W = 16;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned PAGE_W = 32;
	localparam int unsigned OFF_W  = 12;
	localparam int unsigned LEN_W  = 13;
	localparam int unsigned FREE_W = 13;
	// Stored offsets keep the full page size, which a zero-length record can reach.
	localparam int unsigned END_W  = $clog2(PAGE_BYTES + 1);

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_READ   = 2'd1;
	localparam op_t OP_UPDATE = 2'd2;
	localparam op_t OP_DELETE = 2'd3;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_NO_SPACE = 3'd1;
	localparam status_t ST_RANGE    = 3'd2;
	localparam status_t ST_EMPTY    = 3'd3;
	localparam status_t ST_TOO_LONG = 3'd4;

	typedef struct packed {
		logic             used;
		logic [END_W-1:0] offset;
		logic [LEN_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_stat_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_out;
		logic [PAGE_W-1:0] page_out;
		logic [OFF_W-1:0]  record_offset;
		logic [LEN_W-1:0]  length_out;
	} result_t;

endpackage

// ===== design/spd_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one directory request item.
// ----------------------------------------------------------------------------
interface spd_req_if;
	logic                        valid;
	logic                        ready;
	spd_pkg::op_t                op;
	logic [spd_pkg::SLOT_W-1:0]  slot;
	logic [spd_pkg::RLEN_W-1:0]  record_length;

	modport source (output valid, output op, output slot, output record_length, input ready);
	modport sink   (input valid, input op, input slot, input record_length, output ready);
endinterface

// ===== design/spd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one directory result item.
// ----------------------------------------------------------------------------
interface spd_rsp_if;
	logic                        valid;
	logic                        ready;
	spd_pkg::status_t            status;
	logic [spd_pkg::SLOT_W-1:0]  slot_out;
	logic [spd_pkg::PAGE_W-1:0]  page_out;
	logic [spd_pkg::OFF_W-1:0]   record_offset;
	logic [spd_pkg::LEN_W-1:0]   length_out;
	logic [spd_pkg::FREE_W-1:0]  free_bytes;

	modport source (output valid, output status, output slot_out, output page_out,
		output record_offset, output length_out, output free_bytes, input ready);
	modport sink   (input valid, input status, input slot_out, input page_out,
		input record_offset, input length_out, input free_bytes, output ready);
endinterface

// ===== design/spd_dir_ram.sv =====
// ----------------------------------------------------------------------------
// Directory RAM
// One write port and one registered read port holding the slot entries.
// ----------------------------------------------------------------------------
module spd_dir_ram #(
	parameter int unsigned DEPTH = spd_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output spd_pkg::entry_t rd_data,
	input  logic            we,
	input  logic [AW-1:0]   wr_addr,
	input  spd_pkg::entry_t wr_data
);
	import spd_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== design/spd_min_scan.sv =====
// ----------------------------------------------------------------------------
// Data end scanner
// Walks the occupied part of the directory one entry per cycle and keeps the
// smallest offset of the entries that are in use.
// ----------------------------------------------------------------------------
module spd_min_scan #(
	parameter int unsigned MAX_ENTRIES = spd_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned AW          = $clog2(MAX_ENTRIES),
	parameter int unsigned CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [CW-1:0]             count,
	input  spd_pkg::entry_t           rd_data,
	output logic                      rd_en,
	output logic [AW-1:0]             rd_addr,
	output spd_pkg::scan_stat_t       stat,
	output logic [spd_pkg::END_W-1:0] data_end
);
	import spd_pkg::*;

	logic [CW-1:0]    addr_q;
	logic [END_W-1:0] min_q;
	logic             run_q;
	logic             busy_q;
	logic             valid_s1;
	logic             issue;
	logic             done;

	assign issue   = run_q && (addr_q < count);
	assign done    = busy_q && !run_q && !valid_s1;
	assign rd_en   = issue;
	assign rd_addr = addr_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (start) begin
			run_q    <= 1'b1;
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (run_q && !issue) begin
				run_q <= 1'b0;
			end
			valid_s1 <= issue;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= '0;
			min_q  <= END_W'(PAGE_BYTES);
		end else begin
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (valid_s1 && rd_data.used && (rd_data.offset < min_q)) begin
				min_q <= rd_data.offset;
			end
		end
	end

	assign stat     = '{busy: busy_q, done: done};
	assign data_end = min_q;
endmodule

// ===== design/slotted_page_directory.sv =====
// ----------------------------------------------------------------------------
// Slotted page directory
// Insert, read and update pass EXEC and then OUT; a new request waits until IDLE again.
// A successful delete adds a rescan of the data end that walks every allocated entry through
// the single read port of the directory RAM, one entry per cycle.
// A result that waits on the response side holds the sequencer until it is taken.
// Reset clears the entry count, page number and response valid at once and sets the data end to the page size.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slotted_page_directory #(
	parameter int unsigned MAX_ENTRIES = spd_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	spd_req_if.sink                    req,
	spd_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [spd_pkg::PAGE_W-1:0] cfg_wdata
);
	import spd_pkg::*;

	localparam int unsigned AW     = $clog2(MAX_ENTRIES);
	localparam int unsigned CW     = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned XW     = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int unsigned DEW    = $clog2(HEADER_BYTES + MAX_ENTRIES * ENTRY_BYTES + 1);
	localparam int unsigned GW     = (DEW > END_W) ? DEW : END_W;
	localparam int unsigned NEED_W = RLEN_W + 1;

	// Sequencer states. One item is handled at a time: the request is taken in
	// IDLE while the RAM reads the addressed slot, decided in EXEC, optionally
	// followed by a full rescan, and handed to the output register in OUT.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [END_W-1:0]  data_end_q;
	logic [PAGE_W-1:0] page_number_q;
	op_t               op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [RLEN_W-1:0] rlen_q;
	result_t           res_q;
	result_t           out_q;
	logic [FREE_W-1:0] out_free_q;
	logic              out_valid_q;

	logic              accept;
	logic              out_load;
	logic [GW-1:0]     dir_end;
	logic [GW-1:0]     gap_full;
	logic [FREE_W-1:0] gap;
	logic [NEED_W-1:0] need;
	logic [NEED_W-1:0] ins_diff;
	logic [END_W-1:0]  ins_off;
	logic              ins_fail;
	logic [XW-1:0]     slot_x;
	logic [XW-1:0]     req_slot_x;
	logic              slot_oor;

	entry_t            ram_rd_data;
	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	logic              ram_we;
	logic [AW-1:0]     ram_wr_addr;
	entry_t            ram_wr_data;

	logic              scan_rd_en;
	logic [AW-1:0]     scan_rd_addr;
	scan_stat_t        scan_stat;
	logic [END_W-1:0]  scan_data_end;
	logic              scan_start;

	result_t           res_d;
	logic              we_d;
	logic [AW-1:0]     waddr_d;
	entry_t            wdata_d;
	logic              ins_ok_d;
	logic              rescan_d;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// The directory end and the free gap are worked out from plain registers:
	// the gap is the data end less the header and the directory, floored at zero.
	assign dir_end  = GW'(HEADER_BYTES) + GW'(count_q) * GW'(ENTRY_BYTES);
	assign gap_full = (GW'(data_end_q) >= dir_end) ? (GW'(data_end_q) - dir_end) : '0;
	assign gap      = gap_full[FREE_W-1:0];

	// An insert needs room for the record and one more directory entry. The
	// record lands directly below the current data end, which it then becomes.
	assign need     = NEED_W'(rlen_q) + NEED_W'(ENTRY_BYTES);
	assign ins_fail = (count_q >= CW'(MAX_ENTRIES)) || (NEED_W'(gap) < need);
	assign ins_diff = NEED_W'(data_end_q) - NEED_W'(rlen_q);
	assign ins_off  = ins_diff[END_W-1:0];

	assign slot_x     = XW'(slot_q);
	assign req_slot_x = XW'(req.slot);
	assign slot_oor   = (slot_x >= XW'(count_q));

	// While idle the RAM keeps reading the slot on the request port, so the
	// entry of an accepted request is ready in EXEC. The scanner owns the read
	// port during a rescan.
	assign ram_rd_en   = (state_q == S_IDLE) || scan_rd_en;
	assign ram_rd_addr = (state_q == S_SCAN) ? scan_rd_addr : req_slot_x[AW-1:0];

	// Decision for the item held in EXEC.
	always_comb begin
		res_d          = '0;
		res_d.status   = ST_OK;
		res_d.slot_out = slot_q;
		we_d           = 1'b0;
		waddr_d        = slot_x[AW-1:0];
		wdata_d        = '0;
		ins_ok_d       = 1'b0;
		rescan_d       = 1'b0;
		priority if (op_q == OP_INSERT) begin
			res_d.slot_out = '0;
			if (ins_fail) begin
				res_d.status = ST_NO_SPACE;
			end else begin
				ins_ok_d             = 1'b1;
				we_d                 = 1'b1;
				waddr_d              = count_q[AW-1:0];
				wdata_d              = '{used: 1'b1, offset: ins_off, length: LEN_W'(rlen_q)};
				res_d.slot_out       = SLOT_W'(count_q);
				res_d.page_out       = page_number_q;
				res_d.record_offset  = ins_off[OFF_W-1:0];
				res_d.length_out     = LEN_W'(rlen_q);
			end
		end else if (slot_oor) begin
			res_d.status = ST_RANGE;
		end else if (!ram_rd_data.used) begin
			res_d.status = ST_EMPTY;
		end else begin
			unique case (op_q)
				OP_READ: begin
					res_d.record_offset = ram_rd_data.offset[OFF_W-1:0];
					res_d.length_out    = ram_rd_data.length;
				end
				OP_UPDATE: begin
					// Records may only keep or shrink their length in place.
					if (RLEN_W'(ram_rd_data.length) >= rlen_q) begin
						we_d                = 1'b1;
						wdata_d             = ram_rd_data;
						wdata_d.length      = LEN_W'(rlen_q);
						res_d.record_offset = ram_rd_data.offset[OFF_W-1:0];
						res_d.length_out    = LEN_W'(rlen_q);
					end else begin
						res_d.status = ST_TOO_LONG;
					end
				end
				OP_DELETE: begin
					// The freed record may have been the lowest one, so the data
					// end is found again by a full pass over the directory.
					we_d     = 1'b1;
					wdata_d  = '0;
					rescan_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign ram_we      = (state_q == S_EXEC) && we_d;
	assign ram_wr_addr = waddr_d;
	assign ram_wr_data = wdata_d;
	assign scan_start  = (state_q == S_EXEC) && rescan_d;

	// The output register is loaded when it is empty or being drained, so a
	// waiting result never blocks the sequencer for longer than it must.
	assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	spd_dir_ram #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

	spd_min_scan #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW),
		.CW          (CW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.count    (count_q),
		.rd_data  (ram_rd_data),
		.rd_en    (scan_rd_en),
		.rd_addr  (scan_rd_addr),
		.stat     (scan_stat),
		.data_end (scan_data_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			data_end_q    <= END_W'(PAGE_BYTES);
			page_number_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				page_number_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ins_ok_d) begin
						count_q    <= count_q + 1'b1;
						data_end_q <= ins_off;
					end
					state_q <= rescan_d ? S_SCAN : S_OUT;
				end
				S_SCAN: begin
					if (scan_stat.done) begin
						data_end_q <= scan_data_end;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			slot_q <= req.slot;
			rlen_q <= req.record_length;
		end
		if (state_q == S_EXEC) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q      <= res_q;
			out_free_q <= gap;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.slot_out      = out_q.slot_out;
	assign rsp.page_out      = out_q.page_out;
	assign rsp.record_offset = out_q.record_offset;
	assign rsp.length_out    = out_q.length_out;
	assign rsp.free_bytes    = out_free_q;

	// The entry count never passes the directory depth.
	`SPD_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_ENTRIES))
	// The data end never falls below the end of the directory.
	`SPD_ASSERT_IMP(a_gap_nonneg, clk, arst_n, 1'b1, GW'(data_end_q) >= dir_end)
	// The RAM is never written while the scanner walks it.
	`SPD_ASSERT_IMP(a_no_write_in_scan, clk, arst_n, ram_we, !scan_stat.busy)
	// An accepted item is decided in the very next cycle.
	`SPD_ASSERT_NEXT(a_exec_after_accept, clk, arst_n, accept, state_q == S_EXEC)
endmodule
